// ===== src/assert_macros.svh =====
// Assertion macros for the checker file of this block.
// Include with the bare file name; each use stands on its own line.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define TSCT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");

// Property checked on every clock edge, reset included.
`define TSCT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("check failed");

`endif

// ===== src/tsct_pkg.sv =====
// Package for the Taylor sine/cosine/tangent unit: constants, codes and sequencer states.
// No dependencies; the interface, unit, checker and testbench files refer to it by scoped names.
package tsct_pkg;

  localparam int FRAC_BITS = 24;
  localparam int MAX_TERMS = 40;

  // Field widths.
  localparam int CMD_W   = 2;
  localparam int ANGLE_W = 32;
  localparam int RES_W   = 48;
  localparam int THR_W   = 8;

  // Internal widths (bounded by |x| < 2*pi in Q24).
  localparam int MAG_W  = 32;               // series term magnitude
  localparam int X2_W   = 30;               // x*x in Q24
  localparam int SUM_W  = 48;               // partial sums
  localparam int NUM_W  = 37;               // term*x*x >> FRAC_BITS
  localparam int SMAG_W = 34;               // |sine| and |cosine| sums
  localparam int DQ_W   = SMAG_W + FRAC_BITS; // divider dividend/quotient
  localparam int DR_W   = SMAG_W + 1;       // divider remainder
  localparam int K_W    = 7;
  localparam int N_W    = 7;
  localparam int CNT_W  = 6;

  // 2*pi rounded to nearest in Q24.
  localparam logic [ANGLE_W-1:0] TWO_PI = 32'h0648_7ED5;

  localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

  // Operation codes.
  localparam logic [CMD_W-1:0] CMD_SIN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COS = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TAN = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_SETUP,
    ST_CHECK,
    ST_MULT,
    ST_DLOAD,
    ST_DIV,
    ST_UPDATE,
    ST_TAN_START,
    ST_TAN_END,
    ST_FINISH
  } state_t;

endpackage

// ===== src/tsct_ifs.sv =====
// Channel interfaces of the Taylor sine/cosine/tangent unit.
// Depends on tsct_pkg for field widths.
interface tsct_req_if;
  logic                          valid;
  logic                          ready;
  logic [tsct_pkg::CMD_W-1:0]    cmd;
  logic signed [tsct_pkg::ANGLE_W-1:0] angle;
  modport source (output valid, cmd, angle, input ready);
  modport sink   (input valid, cmd, angle, output ready);
endinterface

interface tsct_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [tsct_pkg::RES_W-1:0] result;
  logic                              overflow;
  modport source (output valid, result, overflow, input ready);
  modport sink   (input valid, result, overflow, output ready);
endinterface

interface tsct_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tsct_pkg::THR_W-1:0]   data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== src/taylor_sine_cosine_tangent_unit.sv =====
// Taylor-series sine, cosine and tangent unit with one shared multiplier and divider.
// Depends on tsct_pkg and the channel interfaces in tsct_ifs.sv.
//
// Usage:
//   req carries one beat per operation: cmd (0 sine, 1 cosine, 2 tangent) and a
//   signed Q7.24 angle. rsp returns one beat per request: a signed Q23.24 result
//   and an overflow flag for a saturated tangent. cfg writes the 8-bit term
//   threshold (reset value 1); its ready is always high.
//   The angle is reduced by repeated subtraction of 2*pi, then x*x is formed on
//   the shared multiplier. Each series term after the first takes a check step, a
//   multiply, a divider load, the bit-serial divider and an update, for up to 39
//   such terms. A tangent runs both series and then a division.
//   One operation is in flight at a time; req.ready is high only while idle.
//   The finished result sits in an output register, so the next request is
//   taken while the receiver stalls; the unit then waits at the end of that
//   operation until the earlier beat is taken.
//   rst (synchronous) drops rsp.valid, returns to idle and sets threshold 1.
module taylor_sine_cosine_tangent_unit (
  input  logic          clk,
  input  logic          rst,
  tsct_req_if.sink      req,
  tsct_rsp_if.source    rsp,
  tsct_cfg_if.sink      cfg
);

  tsct_pkg::state_t state, state_next;

  logic [tsct_pkg::THR_W-1:0]   thr;
  logic [tsct_pkg::CMD_W-1:0]   cmd;
  logic                         x_neg;
  logic [tsct_pkg::ANGLE_W-1:0] amag;
  logic [63:0]                  prod;
  logic [tsct_pkg::X2_W-1:0]    x2;
  logic [tsct_pkg::MAG_W-1:0]   mag;
  logic                         neg;
  logic [tsct_pkg::K_W-1:0]     k;
  logic [tsct_pkg::N_W-1:0]     n;
  logic signed [tsct_pkg::SUM_W-1:0] sum;
  logic signed [tsct_pkg::SUM_W-1:0] s_sum;
  logic                         cos_phase;
  logic                         tan_div;
  logic [tsct_pkg::DQ_W-1:0]    dv_q;
  logic [tsct_pkg::DR_W-1:0]    dv_r;
  logic [tsct_pkg::DR_W-1:0]    dv_d;
  logic [tsct_pkg::CNT_W-1:0]   dv_cnt;
  logic                         rsp_valid;
  logic [tsct_pkg::RES_W-1:0]   res;
  logic                         ovf;
  logic [tsct_pkg::RES_W-1:0]   rsp_result;
  logic                         rsp_overflow;

  // Shared multiplier operands.
  logic [31:0] op_a, op_b;
  logic [63:0] prod_w;
  always_comb begin
    if (state == tsct_pkg::ST_SQUARE) begin
      op_a = amag;
      op_b = amag;
    end else begin
      op_a = mag;
      op_b = {2'b0, x2};
    end
    prod_w = {32'b0, op_a} * {32'b0, op_b};
  end

  // Divider step: shift in one dividend bit and try a subtraction.
  logic [tsct_pkg::DR_W-1:0] dv_sh;
  logic                      dv_ge;
  always_comb begin
    dv_sh = {dv_r[tsct_pkg::DR_W-2:0], dv_q[tsct_pkg::DQ_W-1]};
    dv_ge = (dv_sh >= dv_d);
  end

  // Series divisor k*(k-1).
  logic [2*tsct_pkg::K_W-1:0] den;
  assign den = {{tsct_pkg::K_W{1'b0}}, k} * {{tsct_pkg::K_W{1'b0}}, k - 7'd1};

  // Series loop condition and the term update.
  logic go_on;
  logic [tsct_pkg::MAG_W-1:0] mag_new;
  assign go_on = (mag > {{(tsct_pkg::MAG_W-tsct_pkg::THR_W){1'b0}}, thr}) &&
                 (n < tsct_pkg::N_W'(tsct_pkg::MAX_TERMS));
  assign mag_new = dv_q[tsct_pkg::MAG_W-1:0];

  // Tangent operands and result.
  logic [tsct_pkg::SUM_W-1:0] ns_full, nc_full;
  logic                       t_neg;
  logic [tsct_pkg::DQ_W-1:0]  t_lim;
  logic [tsct_pkg::RES_W-1:0] t_mag;
  always_comb begin
    ns_full = s_sum[tsct_pkg::SUM_W-1] ? -s_sum : s_sum;
    nc_full = sum[tsct_pkg::SUM_W-1] ? -sum : sum;
    t_neg   = (s_sum[tsct_pkg::SUM_W-1] != sum[tsct_pkg::SUM_W-1]) && (s_sum != '0);
    t_lim   = t_neg ? tsct_pkg::DQ_W'({1'b0, tsct_pkg::RES_MIN})
                    : tsct_pkg::DQ_W'({1'b0, tsct_pkg::RES_MAX});
    t_mag   = (dv_q > t_lim) ? t_lim[tsct_pkg::RES_W-1:0] : dv_q[tsct_pkg::RES_W-1:0];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      tsct_pkg::ST_IDLE: begin
        if (req.valid) begin
          if (req.cmd == tsct_pkg::CMD_SIN || req.cmd == tsct_pkg::CMD_COS ||
              req.cmd == tsct_pkg::CMD_TAN) begin
            state_next = tsct_pkg::ST_REDUCE;
          end else begin
            state_next = tsct_pkg::ST_FINISH;
          end
        end
      end
      tsct_pkg::ST_REDUCE: begin
        if (amag < tsct_pkg::TWO_PI) state_next = tsct_pkg::ST_SQUARE;
      end
      tsct_pkg::ST_SQUARE: state_next = tsct_pkg::ST_SETUP;
      tsct_pkg::ST_SETUP:  state_next = tsct_pkg::ST_CHECK;
      tsct_pkg::ST_CHECK: begin
        if (go_on) begin
          state_next = tsct_pkg::ST_MULT;
        end else if (cmd == tsct_pkg::CMD_TAN && cos_phase) begin
          state_next = tsct_pkg::ST_TAN_START;
        end else if (cmd != tsct_pkg::CMD_TAN) begin
          state_next = tsct_pkg::ST_FINISH;
        end
      end
      tsct_pkg::ST_MULT:  state_next = tsct_pkg::ST_DLOAD;
      tsct_pkg::ST_DLOAD: state_next = tsct_pkg::ST_DIV;
      tsct_pkg::ST_DIV: begin
        if (dv_cnt == 6'd1) state_next = tan_div ? tsct_pkg::ST_TAN_END : tsct_pkg::ST_UPDATE;
      end
      tsct_pkg::ST_UPDATE: state_next = tsct_pkg::ST_CHECK;
      tsct_pkg::ST_TAN_START: begin
        state_next = (sum == '0) ? tsct_pkg::ST_FINISH : tsct_pkg::ST_DIV;
      end
      tsct_pkg::ST_TAN_END: state_next = tsct_pkg::ST_FINISH;
      tsct_pkg::ST_FINISH: begin
        if (!rsp_valid || rsp.ready) state_next = tsct_pkg::ST_IDLE;
      end
      default: state_next = tsct_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    req.ready    = (state == tsct_pkg::ST_IDLE);
    cfg.ready    = 1'b1;
    rsp.valid    = rsp_valid;
    rsp.result   = rsp_result;
    rsp.overflow = rsp_overflow;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tsct_pkg::ST_IDLE;
      thr       <= 8'd1;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) thr <= cfg.data;
      if (state == tsct_pkg::ST_FINISH && (!rsp_valid || rsp.ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      tsct_pkg::ST_IDLE: begin
        cmd       <= req.cmd;
        x_neg     <= req.angle[tsct_pkg::ANGLE_W-1];
        amag      <= req.angle[tsct_pkg::ANGLE_W-1] ? -req.angle : req.angle;
        cos_phase <= 1'b0;
        tan_div   <= 1'b0;
        res       <= '0;
        ovf       <= 1'b0;
      end
      tsct_pkg::ST_REDUCE: begin
        if (amag >= tsct_pkg::TWO_PI) amag <= amag - tsct_pkg::TWO_PI;
      end
      tsct_pkg::ST_SQUARE: prod <= prod_w;
      tsct_pkg::ST_SETUP: begin
        x2 <= prod[tsct_pkg::FRAC_BITS +: tsct_pkg::X2_W];
        n  <= 7'd1;
        if (cmd == tsct_pkg::CMD_COS) begin
          mag <= 32'd1 << tsct_pkg::FRAC_BITS;
          neg <= 1'b0;
          k   <= 7'd2;
          sum <= tsct_pkg::SUM_W'(1) << tsct_pkg::FRAC_BITS;
        end else begin
          mag <= amag;
          neg <= x_neg;
          k   <= 7'd3;
          sum <= x_neg ? -tsct_pkg::SUM_W'(amag) : tsct_pkg::SUM_W'(amag);
        end
      end
      tsct_pkg::ST_CHECK: begin
        if (!go_on) begin
          if (cmd == tsct_pkg::CMD_TAN && !cos_phase) begin
            // Sine done; keep it and start the cosine series.
            s_sum     <= sum;
            cos_phase <= 1'b1;
            mag       <= 32'd1 << tsct_pkg::FRAC_BITS;
            neg       <= 1'b0;
            k         <= 7'd2;
            n         <= 7'd1;
            sum       <= tsct_pkg::SUM_W'(1) << tsct_pkg::FRAC_BITS;
          end else if (cmd != tsct_pkg::CMD_TAN) begin
            res <= sum;
          end
        end
      end
      tsct_pkg::ST_MULT: prod <= prod_w;
      tsct_pkg::ST_DLOAD: begin
        dv_q   <= {prod[tsct_pkg::FRAC_BITS +: tsct_pkg::NUM_W],
                   {(tsct_pkg::DQ_W-tsct_pkg::NUM_W){1'b0}}};
        dv_r   <= '0;
        dv_d   <= tsct_pkg::DR_W'(den);
        dv_cnt <= 6'(tsct_pkg::NUM_W);
      end
      tsct_pkg::ST_DIV: begin
        dv_r   <= dv_ge ? dv_sh - dv_d : dv_sh;
        dv_q   <= {dv_q[tsct_pkg::DQ_W-2:0], dv_ge};
        dv_cnt <= dv_cnt - 6'd1;
      end
      tsct_pkg::ST_UPDATE: begin
        mag <= mag_new;
        neg <= !neg;
        sum <= (!neg) ? sum - tsct_pkg::SUM_W'(mag_new) : sum + tsct_pkg::SUM_W'(mag_new);
        k   <= k + 7'd2;
        n   <= n + 7'd1;
      end
      tsct_pkg::ST_TAN_START: begin
        if (sum == '0) begin
          // Zero cosine: saturate by the sign of the sine.
          res <= s_sum[tsct_pkg::SUM_W-1] ? tsct_pkg::RES_MIN : tsct_pkg::RES_MAX;
          ovf <= 1'b1;
        end else begin
          tan_div <= 1'b1;
          dv_q    <= {ns_full[tsct_pkg::SMAG_W-1:0], {tsct_pkg::FRAC_BITS{1'b0}}};
          dv_r    <= '0;
          dv_d    <= {1'b0, nc_full[tsct_pkg::SMAG_W-1:0]};
          dv_cnt  <= 6'(tsct_pkg::DQ_W);
        end
      end
      tsct_pkg::ST_TAN_END: begin
        res <= t_neg ? -t_mag : t_mag;
        ovf <= (dv_q > t_lim);
      end
      tsct_pkg::ST_FINISH: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_result   <= res;
          rsp_overflow <= ovf;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== src/tsct_checker.sv =====
// Port-level checker for the Taylor sine/cosine/tangent unit, with its bind.
// Depends on assert_macros.svh and tsct_pkg.
`include "assert_macros.svh"

module tsct_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [tsct_pkg::RES_W-1:0]  result,
  input logic                        overflow
);

  // An accepted request keeps req_ready low in the cycle after acceptance.
  `TSCT_ASSERT(a_busy_after_req, clk, rst, (req_valid && req_ready) |=> !req_ready)

  // A stalled response beat holds its value.
  `TSCT_ASSERT(a_rsp_hold, clk, rst, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(result)))

  // Overflow is only raised on a saturated result.
  `TSCT_ASSERT(a_ovf_sat, clk, rst, (rsp_valid && overflow) |-> (result == tsct_pkg::RES_MAX || result == tsct_pkg::RES_MIN))

  // Reset leaves no response pending.
  `TSCT_ASSERT_ALWAYS(a_rst_clear, clk, rst |=> !rsp_valid)

endmodule

bind taylor_sine_cosine_tangent_unit tsct_checker u_tsct_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .result    (rsp.result),
  .overflow  (rsp.overflow)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for the Taylor sine/cosine/tangent unit.
// Depends on tsct_pkg, the channel interfaces in tsct_ifs.sv and the unit's RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 40000;
  localparam logic [tsct_pkg::CMD_W-1:0] CMD_NONE = 2'd3;
  localparam longint HALF_PI = 64'sd26353589;
  localparam longint ANGLE_SPAN = 64'sd105414357;

  typedef struct packed {
    logic [tsct_pkg::RES_W-1:0] result;
    logic                       overflow;
  } trig_out_t;

  typedef struct {
    logic [tsct_pkg::CMD_W-1:0]   cmd;
    logic [tsct_pkg::ANGLE_W-1:0] angle;
    bit                           typed;
    trig_out_t                    value;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tsct_req_if req_ch();
  tsct_rsp_if rsp_ch();
  tsct_cfg_if cfg_ch();

  taylor_sine_cosine_tangent_unit dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch), .cfg(cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Testbench copy of the threshold register and the results still owed.
  logic [tsct_pkg::THR_W-1:0] thr_model = 8'd1;
  trig_out_t        owed_q[$];
  int               fail_count = 0;
  int               idle_cycles = 0;
  bit               no_stall = 1'b0;
  bit               row_typed = 1'b0;
  trig_out_t        row_value;

  // (a*b) >> FRAC_BITS on magnitudes.
  function automatic longint unsigned mul_frac(longint unsigned a, longint unsigned b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[tsct_pkg::FRAC_BITS +: 64];
  endfunction

  // Partial Taylor sum, starting at x for sine or at one for cosine.
  function automatic longint taylor_sum(longint x, bit is_sine);
    longint unsigned ax, x2, mag, k;
    bit neg;
    longint acc;
    int n;
    ax = (x < 0) ? longint'(-x) : x;
    x2 = mul_frac(ax, ax);
    n = 1;
    if (is_sine) begin
      mag = ax; neg = (x < 0); k = 3;
    end else begin
      mag = 64'd1 << tsct_pkg::FRAC_BITS; neg = 1'b0; k = 2;
    end
    acc = neg ? -longint'(mag) : longint'(mag);
    while (mag > {56'd0, thr_model} && n < tsct_pkg::MAX_TERMS) begin
      mag = mul_frac(mag, x2) / (k * (k - 1));
      neg = !neg;
      acc += neg ? -longint'(mag) : longint'(mag);
      k += 2;
      n++;
    end
    return acc;
  endfunction

  function automatic longint reduce_angle(logic [tsct_pkg::ANGLE_W-1:0] angle);
    longint a;
    a = longint'($signed(angle));
    return a % longint'($signed(tsct_pkg::TWO_PI));
  endfunction

  function automatic trig_out_t predict_trig(logic [tsct_pkg::CMD_W-1:0] cmd,
                                             logic [tsct_pkg::ANGLE_W-1:0] angle);
    trig_out_t o;
    longint x, s, c, v;
    longint unsigned ns, nc, lim, q, r;
    bit neg;
    x = reduce_angle(angle);
    o = '0;
    if (cmd == tsct_pkg::CMD_SIN) begin
      v = taylor_sum(x, 1'b1);
      o.result = v[tsct_pkg::RES_W-1:0];
    end else if (cmd == tsct_pkg::CMD_COS) begin
      v = taylor_sum(x, 1'b0);
      o.result = v[tsct_pkg::RES_W-1:0];
    end else if (cmd == tsct_pkg::CMD_TAN) begin
      s = taylor_sum(x, 1'b1);
      c = taylor_sum(x, 1'b0);
      neg = (s < 0) != (c < 0);
      if (c == 0) begin
        o.result = (s >= 0) ? tsct_pkg::RES_MAX : tsct_pkg::RES_MIN;
        o.overflow = 1'b1;
      end else begin
        ns = (s < 0) ? longint'(-s) : s;
        nc = (c < 0) ? longint'(-c) : c;
        lim = neg ? (64'd1 << (tsct_pkg::RES_W - 1)) : ((64'd1 << (tsct_pkg::RES_W - 1)) - 1);
        q = ns / nc;
        r = ns % nc;
        if (s == 0) neg = 1'b0;
        for (int i = 0; i < tsct_pkg::FRAC_BITS && q <= lim; i++) begin
          r = r << 1;
          q = q << 1;
          if (r >= nc) begin
            r -= nc;
            q |= 64'd1;
          end
        end
        if (q > lim) begin
          q = lim;
          o.overflow = 1'b1;
        end
        v = neg ? -longint'(q) : longint'(q);
        o.result = v[tsct_pkg::RES_W-1:0];
      end
    end
    return o;
  endfunction

  // Stimulus drive at the falling edge.
  always @(negedge clk) begin
    rsp_ch.ready <= rst ? 1'b0 : (no_stall || $urandom_range(0, 99) >= 20);
  end

  // Beat monitors, scoreboard and watchdog at the rising edge.
  always @(posedge clk) begin
    trig_out_t want;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) thr_model <= cfg_ch.data;
      if (req_ch.valid && req_ch.ready)
        owed_q.push_back(row_typed ? row_value : predict_trig(req_ch.cmd, req_ch.angle));
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected result beat %h ovf %b", $time, rsp_ch.result,
                   rsp_ch.overflow);
          fail_count++;
        end else begin
          want = owed_q.pop_front();
          if (rsp_ch.result !== want.result) begin
            $display("%0t: result expected %h actual %h", $time, want.result, rsp_ch.result);
            fail_count++;
          end
          if (rsp_ch.overflow !== want.overflow) begin
            $display("%0t: overflow expected %b actual %b", $time, want.overflow,
                     rsp_ch.overflow);
            fail_count++;
          end
        end
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else
        idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_op(logic [tsct_pkg::CMD_W-1:0] cmd, logic [tsct_pkg::ANGLE_W-1:0] angle,
                         bit typed, trig_out_t value);
    while (!no_stall && $urandom_range(0, 99) < 20) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.cmd = cmd;
    req_ch.angle = angle;
    row_typed = typed;
    row_value = value;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    req_ch.valid = 1'b0;
  endtask

  task automatic drain_results();
    while (owed_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_threshold(logic [tsct_pkg::THR_W-1:0] value);
    drain_results();
    cfg_ch.valid = 1'b1;
    cfg_ch.data = value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [tsct_pkg::ANGLE_W-1:0] random_angle();
    longint a;
    if ($urandom_range(0, 1)) return $urandom;
    a = longint'($urandom_range(0, 2 * ANGLE_SPAN)) - ANGLE_SPAN;
    return a[tsct_pkg::ANGLE_W-1:0];
  endfunction

  task automatic random_ops(int count);
    logic [tsct_pkg::CMD_W-1:0] cmd;
    for (int i = 0; i < count; i++) begin
      cmd = ($urandom_range(0, 19) == 0) ? CMD_NONE
                                         : tsct_pkg::CMD_W'($urandom_range(0, 2));
      send_op(cmd, random_angle(), 1'b0, '0);
    end
  endtask

  initial begin
    stim_row_t rows[$];
    longint zero_cos_ang, tiny_cos_ang, c, a;
    trig_out_t none;
    none = '0;
    req_ch.valid = 1'b0;
    req_ch.cmd = tsct_pkg::CMD_SIN;
    req_ch.angle = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    rsp_ch.ready = 1'b0;

    // Look near pi/2 for angles whose cosine sum is exactly zero or one LSB.
    zero_cos_ang = HALF_PI;
    tiny_cos_ang = HALF_PI;
    for (longint d = -300; d <= 300; d++) begin
      a = HALF_PI + d;
      c = taylor_sum(a, 1'b0);
      if (c == 0) zero_cos_ang = a;
      else if (c == 1 || c == -1) tiny_cos_ang = a;
    end

    // Directed table; typed rows hold values that follow directly from the definition.
    rows = '{
      '{tsct_pkg::CMD_SIN, 32'h0000_0000, 1'b1, '{48'd0, 1'b0}},
      '{tsct_pkg::CMD_COS, 32'h0000_0000, 1'b1, '{48'h00_0001_000000, 1'b0}},
      '{tsct_pkg::CMD_TAN, 32'h0000_0000, 1'b1, '{48'd0, 1'b0}},
      '{CMD_NONE, 32'h7FFF_FFFF, 1'b1, '{48'd0, 1'b0}},
      '{CMD_NONE, 32'h8000_0000, 1'b1, '{48'd0, 1'b0}},
      '{tsct_pkg::CMD_SIN, tsct_pkg::TWO_PI, 1'b1, '{48'd0, 1'b0}},
      '{tsct_pkg::CMD_SIN, -tsct_pkg::TWO_PI, 1'b1, '{48'd0, 1'b0}},
      '{tsct_pkg::CMD_SIN, 32'h7FFF_FFFF, 1'b0, none},
      '{tsct_pkg::CMD_COS, 32'h7FFF_FFFF, 1'b0, none},
      '{tsct_pkg::CMD_TAN, 32'h7FFF_FFFF, 1'b0, none},
      '{tsct_pkg::CMD_SIN, 32'h8000_0000, 1'b0, none},
      '{tsct_pkg::CMD_COS, 32'h8000_0000, 1'b0, none},
      '{tsct_pkg::CMD_TAN, 32'h8000_0000, 1'b0, none},
      '{tsct_pkg::CMD_COS, 32'hFFFF_FFFF, 1'b0, none},
      '{tsct_pkg::CMD_SIN, 32'h0000_0001, 1'b0, none},
      '{tsct_pkg::CMD_SIN, tsct_pkg::TWO_PI - 1, 1'b0, none},
      '{tsct_pkg::CMD_SIN, 32'(HALF_PI), 1'b0, none},
      '{tsct_pkg::CMD_COS, 32'(2 * HALF_PI), 1'b0, none},
      '{tsct_pkg::CMD_TAN, 32'(zero_cos_ang), 1'b0, none},
      '{tsct_pkg::CMD_TAN, 32'(-zero_cos_ang), 1'b0, none},
      '{tsct_pkg::CMD_TAN, 32'(tiny_cos_ang), 1'b0, none},
      '{tsct_pkg::CMD_TAN, 32'(-tiny_cos_ang), 1'b0, none},
      '{tsct_pkg::CMD_TAN, 32'h0300_0000, 1'b0, none}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) send_op(rows[i].cmd, rows[i].angle, rows[i].typed, rows[i].value);

    // Random phases across threshold settings, extremes first.
    write_threshold(8'd0);
    random_ops(40);
    write_threshold(8'd255);
    random_ops(60);
    write_threshold(8'd1);
    random_ops(80);
    no_stall = 1'b1;
    random_ops(100);
    no_stall = 1'b0;
    drain_results();
    random_ops(20);
    for (int p = 0; p < 4; p++) begin
      write_threshold(tsct_pkg::THR_W'($urandom_range(0, 255)));
      random_ops(50);
    end

    drain_results();
    repeat (200) @(negedge clk);
    if (fail_count == 0 && owed_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/tsct_pkg.sv
src/tsct_ifs.sv
src/taylor_sine_cosine_tangent_unit.sv
src/tsct_checker.sv
dv/testbench.sv
